### src/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Types, constants and round helpers shared by the SHA-1 stream hasher files.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    // Sequencer states (one-hot)
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef logic [31:0] word_t;

    localparam int          NUM_CHAIN     = 5;
    localparam int          WIN_DEPTH     = 16;
    localparam logic [6:0]  LAST_ROUND    = 7'd79;
    localparam logic [5:0]  LAST_FILL     = 6'd63;
    localparam logic [5:0]  PAD_LIMIT     = 6'd55;
    localparam logic [5:0]  LEN_START     = 6'd56;
    localparam logic [7:0]  PAD_BYTE      = 8'h80;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

    localparam word_t INIT_CHAIN [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    // Round boundaries
    localparam logic [6:0] R20 = 7'd20;
    localparam logic [6:0] R40 = 7'd40;
    localparam logic [6:0] R60 = 7'd60;

    // Round constant for round t
    function automatic word_t round_k(input logic [6:0] t);
        word_t k;
        if (t < R20)
            k = K0;
        else if (t < R40)
            k = K1;
        else if (t < R60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

    // Boolean function for round t: choose, parity, majority, parity
    function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        if (t < R20)
            f = (b & c) | (~b & d);
        else if (t < R40 || t >= R60)
            f = b ^ c ^ d;
        else
            f = (b & c) | (b & d) | (c & d);
        return f;
    endfunction

endpackage

### src/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream with one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction carries an optional
//   byte (has_byte) and an optional end of message (message_end). in_ready
//   is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready): after an end of message, five
//   transactions carry digest words H0..H4, word_index 0..4, last_word on
//   the fifth. Words are held until taken; a stalled receiver simply holds
//   the block in its output phase.
// Sequence:
//   A byte that does not complete a 64-byte block leaves the sequencer idle.
//   A byte that completes one starts 80 rounds through the single round unit,
//   one per cycle, then one chaining add. An end of message shifts padding
//   in one byte per cycle up to the block boundary, then compresses one or
//   two blocks, then shows five words at one per cycle when the receiver
//   is ready.
// Reset: asynchronous, active low; returns the chaining words to the SHA-1
//   initial values and clears the byte and bit counts.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1sh_pkg::state_t state_reg, state_next;

    sha1sh_pkg::word_t chain_reg [sha1sh_pkg::NUM_CHAIN];
    sha1sh_pkg::word_t chain_next [sha1sh_pkg::NUM_CHAIN];
    sha1sh_pkg::word_t win_reg [sha1sh_pkg::WIN_DEPTH];
    sha1sh_pkg::word_t win_next [sha1sh_pkg::WIN_DEPTH];
    sha1sh_pkg::word_t work_reg [sha1sh_pkg::NUM_CHAIN];
    sha1sh_pkg::word_t work_next [sha1sh_pkg::NUM_CHAIN];

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pend_reg, pend_next;     // end of message waits on a compress
    logic        pad_reg, pad_next;       // padding of this message under way
    logic        final_reg, final_next;   // current pad block carries length
    logic        first_reg, first_next;   // next pad byte is the 0x80 marker

    logic        in_fire;
    logic        out_fire;
    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    sha1sh_pkg::word_t w_new;
    sha1sh_pkg::word_t round_sum;

    assign in_ready  = (state_reg == sha1sh_pkg::ST_IDLE);
    assign out_valid = (state_reg == sha1sh_pkg::ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // Output fields straight from registers
    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == sha1sh_pkg::LAST_WORD_IDX);
    always_comb
    begin
        case (out_idx_reg)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    // Padding byte: marker, zero fill, or big-endian bit length
    assign len_byte = 8'(bits_reg >> {~fill_reg[2:0], 3'b000});
    always_comb
    begin
        if (first_reg)
            pad_byte = sha1sh_pkg::PAD_BYTE;
        else if (final_reg && (fill_reg >= sha1sh_pkg::LEN_START))
            pad_byte = len_byte;
        else
            pad_byte = 8'h00;
    end

    // Message schedule feedback and shared round adder
    assign w_new = {win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]} << 1
                 | {31'd0, (win_reg[13][31] ^ win_reg[8][31]
                            ^ win_reg[2][31] ^ win_reg[0][31])};
    assign round_sum = {work_reg[0][26:0], work_reg[0][31:27]}
                     + sha1sh_pkg::round_f(round_reg, work_reg[1], work_reg[2],
                                           work_reg[3])
                     + work_reg[4] + win_reg[0]
                     + sha1sh_pkg::round_k(round_reg);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        pend_next    = pend_reg;
        pad_next     = pad_reg;
        final_next   = final_reg;
        first_next   = first_reg;
        chain_next   = chain_reg;
        work_next    = work_reg;
        shift_en     = 1'b0;
        shift_byte   = data_byte;

        unique case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_byte)
                    begin
                        shift_en  = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (has_byte && (fill_reg == sha1sh_pkg::LAST_FILL))
                    begin
                        pend_next  = message_end;
                        round_next = 7'd0;
                        work_next  = chain_reg;
                        state_next = sha1sh_pkg::ST_ROUND;
                    end
                    else if (message_end)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        final_next = (fill_next <= sha1sh_pkg::PAD_LIMIT);
                        state_next = sha1sh_pkg::ST_PAD;
                    end
                end
            end
            sha1sh_pkg::ST_PAD:
            begin
                shift_en   = 1'b1;
                shift_byte = pad_byte;
                first_next = 1'b0;
                fill_next  = fill_reg + 6'd1;
                if (fill_reg == sha1sh_pkg::LAST_FILL)
                begin
                    round_next = 7'd0;
                    work_next  = chain_reg;
                    state_next = sha1sh_pkg::ST_ROUND;
                end
            end
            sha1sh_pkg::ST_ROUND:
            begin
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[1] = work_reg[0];
                work_next[0] = round_sum;
                round_next   = round_reg + 7'd1;
                if (round_reg == sha1sh_pkg::LAST_ROUND)
                    state_next = sha1sh_pkg::ST_FOLD;
            end
            sha1sh_pkg::ST_FOLD:
            begin
                for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (pad_reg && final_reg)
                begin
                    out_idx_next = 3'd0;
                    state_next   = sha1sh_pkg::ST_OUT;
                end
                else if (pad_reg)
                begin
                    // second pad block: zeros then length
                    final_next = 1'b1;
                    state_next = sha1sh_pkg::ST_PAD;
                end
                else if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                    final_next = 1'b1;
                    state_next = sha1sh_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1sh_pkg::ST_IDLE;
                end
            end
            sha1sh_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    if (out_idx_reg == sha1sh_pkg::LAST_WORD_IDX)
                    begin
                        chain_next   = sha1sh_pkg::INIT_CHAIN;
                        fill_next    = 6'd0;
                        bits_next    = 64'd0;
                        pad_next     = 1'b0;
                        final_next   = 1'b0;
                        out_idx_next = 3'd0;
                        state_next   = sha1sh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase
    end

    // Window: byte shift while filling, word shift with feedback per round
    always_comb
    begin
        win_next = win_reg;
        if (shift_en)
        begin
            for (int j = 0; j < sha1sh_pkg::WIN_DEPTH - 1; j++)
                win_next[j] = {win_reg[j][23:0], win_reg[j + 1][31:24]};
            win_next[sha1sh_pkg::WIN_DEPTH - 1] =
                {win_reg[sha1sh_pkg::WIN_DEPTH - 1][23:0], shift_byte};
        end
        else if (state_reg == sha1sh_pkg::ST_ROUND)
        begin
            for (int j = 0; j < sha1sh_pkg::WIN_DEPTH - 1; j++)
                win_next[j] = win_reg[j + 1];
            win_next[sha1sh_pkg::WIN_DEPTH - 1] = w_new;
        end
    end

    // Control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha1sh_pkg::ST_IDLE;
            chain_reg   <= sha1sh_pkg::INIT_CHAIN;
            fill_reg    <= 6'd0;
            bits_reg    <= 64'd0;
            round_reg   <= 7'd0;
            out_idx_reg <= 3'd0;
            pend_reg    <= 1'b0;
            pad_reg     <= 1'b0;
            final_reg   <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chain_reg   <= chain_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            pend_reg    <= pend_next;
            pad_reg     <= pad_next;
            final_reg   <= final_next;
            first_reg   <= first_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

endmodule

### src/sha1sh_checker.sv
// ----------------------------------------------------------------------------
// sha1sh_checker
// Port-level checks on the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1sh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // No input transaction while digest words are on offer
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while digest words pending");

    // Stalled digest word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
                                    && $stable(word_index))
        else $error("digest word changed under stall");

    // Words come in order 0..4 with no gap
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word
            |=> out_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    // Last flag marks index four only, and the burst ends after it
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == sha1sh_pkg::LAST_WORD_IDX)))
        else $error("last_word does not match word_index");

    a_end_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid && in_ready)
        else $error("output continues after last word");

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (.*);
